>>> rtl/core/websocket_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, idle in reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define WSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types, codes and header constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned PosW = 12;
  localparam logic [PosW-1:0] POS_MAX = 12'd4095;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [PosW-1:0] HDR_PLAIN  = 12'd2;
  localparam logic [PosW-1:0] HDR_MASKED = 12'd6;
  localparam logic [PosW:0]   MIN_BYTES  = 13'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_DATA_OK    = 3'd0,
    ST_CLOSE      = 3'd1,
    ST_TOO_SHORT  = 3'd2,
    ST_EXT_LENGTH = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_OTHER_OP   = 3'd5
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    status_e    status;
  } result_t;

  // Up to two results per input byte; item[0] is always the first one.
  typedef struct packed {
    logic [1:0]    valid;
    result_t [1:0] item;
  } pair_t;

endpackage

>>> rtl/core/websocket_frame_deframer.sv
// Path: an input transfer reaches its first result through the input
// register, then the result register.
// Throughput: one byte per cycle unless m_axis_tready stalls; a buffer's
// last byte with a payload byte yields two results in both output slots.
// Reset: asynchronous, clears header state and all valid flags; no clear pass.
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received buffer byte by byte, unmasks the payload and reports
// a status on the buffer's last byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tlast,  // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] payload_byte, [11:8] frame_opcode_out,
                                     // [12] fin_out, [15:13] frame_status
  output logic        m_axis_tlast,  // last_payload
  output logic        m_axis_tuser   // item_kind
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_eob_q;
  logic             advance, load, out_free, in_xfer;
  wsd_pkg::pair_t   pair;
  wsd_pkg::result_t out_item;

  assign advance       = in_valid_q && (!pair.valid[0] || out_free);
  assign load          = advance && pair.valid[0];
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata;
      in_eob_q  <= s_axis_tlast;
    end
  end

  wsd_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte_q),
    .eob_i     (in_eob_q),
    .advance_i (advance),
    .pair_o    (pair)
  );

  wsd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pair_i  (pair),
    .load_i  (load),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (out_item)
  );

  assign m_axis_tdata = {out_item.status, out_item.fin, out_item.opcode, out_item.payload};
  assign m_axis_tlast = out_item.last;
  assign m_axis_tuser = out_item.kind;

  `WSD_ASSERT_NXT(a_in_hold, in_valid_q && !advance, in_valid_q, "input byte dropped")

endmodule

>>> rtl/core/wsd_parse.sv
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Holds the frame header state and turns one byte into its results.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsd_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    byte_i,
  input  logic          eob_i,
  input  logic          advance_i,
  output wsd_pkg::pair_t pair_o
);

  logic [wsd_pkg::PosW-1:0] pos_q, pos_d;
  logic [3:0]  op_q, op_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [6:0]  len_q, len_d;
  logic [31:0] key_q, key_d;

  logic [wsd_pkg::PosW-1:0] start, start_n, idx;
  logic [wsd_pkg::PosW:0]   count, need;
  logic        key_wr;
  logic [1:0]  key_sel;
  logic        is_data_op;
  logic        pay_hit;
  logic [7:0]  key_byte;
  wsd_pkg::result_t pay_item, st_item;
  wsd_pkg::status_e status;

  always_comb begin
    op_d   = op_q;
    fin_d  = fin_q;
    mask_d = mask_q;
    len_d  = len_q;
    key_d  = key_q;
    if (pos_q == '0) begin
      op_d  = byte_i[3:0];
      fin_d = byte_i[7];
    end else if (pos_q == wsd_pkg::PosW'(1)) begin
      mask_d = byte_i[7];
      len_d  = byte_i[6:0];
    end
    // key bytes sit at positions 2..5
    key_wr  = mask_q && (pos_q >= wsd_pkg::HDR_PLAIN) && (pos_q < wsd_pkg::HDR_MASKED);
    key_sel = pos_q[1:0] ^ 2'b10;
    for (int k = 0; k < 4; k++) begin
      if (key_wr && (key_sel == 2'(k))) begin
        key_d[8*k +: 8] = byte_i;
      end
    end
  end

  always_comb begin
    start      = mask_q ? wsd_pkg::HDR_MASKED : wsd_pkg::HDR_PLAIN;
    idx        = pos_q - start;
    is_data_op = (op_q == wsd_pkg::OP_TEXT) || (op_q == wsd_pkg::OP_BINARY);
    pay_hit    = (pos_q >= start) && (len_q < wsd_pkg::LEN_EXT16) && is_data_op &&
                 (idx < {5'd0, len_q});
    key_byte   = mask_q ? key_q[8*idx[1:0] +: 8] : 8'd0;

    pay_item.kind    = wsd_pkg::KIND_PAYLOAD;
    pay_item.payload = byte_i ^ key_byte;
    pay_item.opcode  = op_d;
    pay_item.fin     = fin_d;
    pay_item.last    = ((idx + wsd_pkg::PosW'(1)) == {5'd0, len_q});
    pay_item.status  = wsd_pkg::ST_DATA_OK;

    // status uses the header as updated by this byte
    start_n = mask_d ? wsd_pkg::HDR_MASKED : wsd_pkg::HDR_PLAIN;
    count   = {1'b0, pos_q} + 13'd1;
    need    = {1'b0, start_n} + {6'd0, len_d};
    if (count < wsd_pkg::MIN_BYTES) begin
      status = wsd_pkg::ST_TOO_SHORT;
    end else if ((len_d == wsd_pkg::LEN_EXT16) || (len_d == wsd_pkg::LEN_EXT64)) begin
      status = wsd_pkg::ST_EXT_LENGTH;
    end else if (count < need) begin
      status = wsd_pkg::ST_INCOMPLETE;
    end else if (op_d == wsd_pkg::OP_CLOSE) begin
      status = wsd_pkg::ST_CLOSE;
    end else if ((op_d == wsd_pkg::OP_TEXT) || (op_d == wsd_pkg::OP_BINARY)) begin
      status = wsd_pkg::ST_DATA_OK;
    end else begin
      status = wsd_pkg::ST_OTHER_OP;
    end

    st_item.kind    = wsd_pkg::KIND_STATUS;
    st_item.payload = 8'd0;
    st_item.opcode  = op_d;
    st_item.fin     = fin_d;
    st_item.last    = 1'b0;
    st_item.status  = status;

    if (pay_hit) begin
      pair_o.valid   = {eob_i, 1'b1};
      pair_o.item[0] = pay_item;
      pair_o.item[1] = st_item;
    end else begin
      pair_o.valid   = {1'b0, eob_i};
      pair_o.item[0] = st_item;
      pair_o.item[1] = st_item;
    end

    if (eob_i) begin
      pos_d = '0;
    end else if (pos_q < wsd_pkg::POS_MAX) begin
      pos_d = pos_q + wsd_pkg::PosW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      op_q   <= '0;
      fin_q  <= 1'b0;
      mask_q <= 1'b0;
      len_q  <= '0;
      key_q  <= '0;
    end else if (advance_i) begin
      pos_q  <= pos_d;
      op_q   <= op_d;
      fin_q  <= fin_d;
      mask_q <= mask_d;
      len_q  <= len_d;
      key_q  <= key_d;
    end
  end

  `WSD_ASSERT_IMP(a_pair_order, pair_o.valid[1], pair_o.valid[0], "second result without first")
  `WSD_ASSERT_NXT(a_pos_restart, advance_i && eob_i, pos_q == '0, "position not cleared")
  `WSD_ASSERT_IMP(a_status_last, pair_o.valid[0] && eob_i,
                  pair_o.item[pair_o.valid[1]].kind == wsd_pkg::KIND_STATUS,
                  "status is not the final result")

endmodule

>>> rtl/core/wsd_outq.sv
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Two-slot output register; the second slot carries the status that
// follows a payload byte on the buffer's last byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsd_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsd_pkg::pair_t   pair_i,
  input  logic             load_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output wsd_pkg::result_t item_o
);

  logic             v0_q, v1_q;
  wsd_pkg::result_t s0_q, s1_q;
  logic             pop;

  assign pop     = v0_q && ready_i;
  // empty after this cycle, so a pair can land
  assign free_o  = !v0_q || (ready_i && !v1_q);
  assign valid_o = v0_q;
  assign item_o  = s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (load_i) begin
      v0_q <= 1'b1;
      v1_q <= pair_i.valid[1];
    end else if (pop) begin
      v0_q <= v1_q;
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s0_q <= pair_i.item[0];
      s1_q <= pair_i.item[1];
    end else if (pop && v1_q) begin
      s0_q <= s1_q;
    end
  end

  `WSD_ASSERT_IMP(a_slot_order, v1_q, v0_q, "second slot filled while first empty")
  `WSD_ASSERT_IMP(a_load_free, load_i, free_o, "pair loaded over pending results")

endmodule
